/* rtl/stripe_request_splitter_assert.svh */
// assertion macros for the stripe request splitter
// expects clk and rst in the scope of the module that uses them
`ifndef STRIPE_REQUEST_SPLITTER_ASSERT_SVH
`define STRIPE_REQUEST_SPLITTER_ASSERT_SVH

// condition implies consequence in the same cycle
`define SSPLIT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define SSPLIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ssplit_pkg.sv */
// shared widths, microcode codes and control store for the stripe request splitter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ssplit_pkg;

  localparam int OFFSET_W  = 40;
  localparam int CNT_W     = 16;
  localparam int BS_W      = 17;
  localparam int MIN_STRIPE_LOG = 10;
  localparam logic [BS_W-1:0] MIN_STRIPE = 17'd1024;
  localparam logic [BS_W-1:0] MAX_STRIPE = 17'd65536;
  localparam logic [BS_W-1:0] STRIPE_RESET = 17'd4096;

  localparam int DEF_NUM_DRIVES        = 2;
  localparam int DEF_MAX_REQUEST_BYTES = 32768;

  localparam int DIV_BITS  = 2;
  localparam int DIV_STEPS = OFFSET_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int QD_W      = OFFSET_W - MIN_STRIPE_LOG;

  localparam int PC_W   = 3;
  localparam int OP_W   = 3;
  localparam int COND_W = 3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [COND_W-1:0] cond_t;
  typedef logic [PC_W-1:0]   pc_t;

  localparam op_t OP_NONE   = 3'd0;
  localparam op_t OP_LOAD   = 3'd1;
  localparam op_t OP_DIV    = 3'd2;
  localparam op_t OP_MUL    = 3'd3;
  localparam op_t OP_FIRST  = 3'd4;
  localparam op_t OP_NEXT   = 3'd5;
  localparam op_t OP_REJECT = 3'd6;

  localparam cond_t C_NEVER   = 3'd0;
  localparam cond_t C_ALWAYS  = 3'd1;
  localparam cond_t C_TOOLONG = 3'd2;
  localparam cond_t C_DIVMORE = 3'd3;
  localparam cond_t C_LAST    = 3'd4;
  localparam cond_t C_NOTLAST = 3'd5;

  localparam pc_t S_LOAD   = 3'd0;
  localparam pc_t S_DIV    = 3'd1;
  localparam pc_t S_MUL    = 3'd2;
  localparam pc_t S_FIRST  = 3'd3;
  localparam pc_t S_NEXT   = 3'd4;
  localparam pc_t S_WRAP   = 3'd5;
  localparam pc_t S_REJECT = 3'd6;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } ctl_t;

  typedef struct packed {
    logic too_long;
    logic div_more;
    logic last;
    logic out_free;
  } stat_t;

  // control store: jump to target when the condition holds, else fall through
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    unique case (pc)
      S_LOAD:   w = '{op: OP_LOAD,   cond: C_TOOLONG, target: S_REJECT};
      S_DIV:    w = '{op: OP_DIV,    cond: C_DIVMORE, target: S_DIV};
      S_MUL:    w = '{op: OP_MUL,    cond: C_NEVER,   target: S_LOAD};
      S_FIRST:  w = '{op: OP_FIRST,  cond: C_LAST,    target: S_LOAD};
      S_NEXT:   w = '{op: OP_NEXT,   cond: C_NOTLAST, target: S_NEXT};
      S_WRAP:   w = '{op: OP_NONE,   cond: C_ALWAYS,  target: S_LOAD};
      S_REJECT: w = '{op: OP_REJECT, cond: C_ALWAYS,  target: S_LOAD};
      default:  w = '{op: OP_NONE,   cond: C_ALWAYS,  target: S_LOAD};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/stripe_request_splitter.sv */
// top level of the stripe request splitter: stripe size register, sequencer and datapath
// depends on ssplit_pkg, ssplit_seq and ssplit_dp
`timescale 1ns / 1ps
`default_nettype none

// Maps one block request onto NUM_DRIVES striped drives and emits one result per
// stripe segment on the seg channel, last_segment marking the final one. A request
// of n segments (1 to 33) runs one load step, 20 steps of the shared divider that
// retires two quotient bits a cycle and reduces the block number by the drive
// count alongside, one multiply step and one step per segment, plus one return
// step when there is more than one segment. A request longer than
// MAX_REQUEST_BYTES gives a single flagged result. Results wait in an output
// register while the next step runs. stripe_bytes is clamped to 1024..65536 when
// a request is taken; the user must see it written only while idle (not enforced).

module stripe_request_splitter
  import ssplit_pkg::*;
#(
  parameter int NUM_DRIVES        = DEF_NUM_DRIVES,
  parameter int MAX_REQUEST_BYTES = DEF_MAX_REQUEST_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [BS_W-1:0]     cfg_data,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic                action,
  input  wire logic [OFFSET_W-1:0] byte_offset,
  input  wire logic [CNT_W-1:0]    byte_count,
  output logic                     seg_valid,
  input  wire logic                seg_stall,
  output logic                     is_write,
  output logic                     drive_index,
  output logic [OFFSET_W-1:0]      drive_byte_offset,
  output logic [CNT_W-1:0]         segment_bytes,
  output logic                     last_segment,
  output logic                     too_long
);

  logic [BS_W-1:0] stripe_bytes;
  ctl_t            ctl;
  stat_t           stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      stripe_bytes <= STRIPE_RESET;
    end else if (cfg_write) begin
      stripe_bytes <= cfg_data;
    end
  end

  ssplit_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  ssplit_dp #(
    .NUM_DRIVES        (NUM_DRIVES),
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .stripe_bytes      (stripe_bytes),
    .action            (action),
    .byte_offset       (byte_offset),
    .byte_count        (byte_count),
    .ctl               (ctl),
    .stat              (stat),
    .seg_valid         (seg_valid),
    .seg_stall         (seg_stall),
    .is_write          (is_write),
    .drive_index       (drive_index),
    .drive_byte_offset (drive_byte_offset),
    .segment_bytes     (segment_bytes),
    .last_segment      (last_segment),
    .too_long          (too_long)
  );

endmodule

`default_nettype wire

/* rtl/ssplit_seq.sv */
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on ssplit_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssplit_seq
  import ssplit_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  output logic       req_stall,
  input  wire stat_t stat,
  output ctl_t       ctl
);

  pc_t    pc;
  pc_t    pc_next;
  uword_t uw;
  logic   go;
  logic   taken;

  assign uw = ucode(pc);

  always_comb begin
    unique case (uw.op)
      OP_LOAD:                       go = req_valid;
      OP_FIRST, OP_NEXT, OP_REJECT:  go = stat.out_free;
      default:                       go = 1'b1;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:  taken = 1'b1;
      C_TOOLONG: taken = stat.too_long;
      C_DIVMORE: taken = stat.div_more;
      C_LAST:    taken = stat.last;
      C_NOTLAST: taken = !stat.last;
      default:   taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (go) begin
      pc_next = taken ? uw.target : pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  assign req_stall = (uw.op != OP_LOAD);
  assign ctl.op    = uw.op;
  assign ctl.go    = go;

endmodule

`default_nettype wire

/* rtl/ssplit_dp.sv */
// datapath: offset divider with drive-count remainder, offset multiply, segment cutter
// depends on ssplit_pkg and stripe_request_splitter_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "stripe_request_splitter_assert.svh"

module ssplit_dp
  import ssplit_pkg::*;
#(
  parameter int NUM_DRIVES        = DEF_NUM_DRIVES,
  parameter int MAX_REQUEST_BYTES = DEF_MAX_REQUEST_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [BS_W-1:0]     stripe_bytes,
  input  wire logic                action,
  input  wire logic [OFFSET_W-1:0] byte_offset,
  input  wire logic [CNT_W-1:0]    byte_count,
  input  wire ctl_t                ctl,
  output stat_t                    stat,
  output logic                     seg_valid,
  input  wire logic                seg_stall,
  output logic                     is_write,
  output logic                     drive_index,
  output logic [OFFSET_W-1:0]      drive_byte_offset,
  output logic [CNT_W-1:0]         segment_bytes,
  output logic                     last_segment,
  output logic                     too_long
);

  localparam int RD_W = $clog2(NUM_DRIVES);
  localparam logic [RD_W:0]   DRV_N    = (RD_W+1)'(NUM_DRIVES);
  localparam logic [RD_W-1:0] DRV_LAST = RD_W'(NUM_DRIVES - 1);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_REQUEST_BYTES);

  logic                  wr;
  logic [BS_W-1:0]       bs;
  logic [OFFSET_W-1:0]   dvd;
  logic [BS_W-1:0]       rem;
  logic [RD_W-1:0]       rd;
  logic [QD_W-1:0]       qd;
  logic [STEP_W-1:0]     cnt;
  logic [OFFSET_W-1:0]   base;
  logic [CNT_W-1:0]      remaining;

  logic [BS_W-1:0]       bs_clamped;
  logic [BS_W:0]         t;
  logic                  qb;
  logic [BS_W:0]         r_w;
  logic [OFFSET_W-1:0]   d_w;
  logic [RD_W:0]         u;
  logic                  q2b;
  logic [RD_W-1:0]       m_w;
  logic [QD_W-1:0]       q_w;

  logic [QD_W+BS_W-1:0]  prod;
  logic                  first;
  logic [BS_W-1:0]       room;
  logic                  fits;
  logic [CNT_W-1:0]      seg;
  logic [CNT_W-1:0]      rem_after;
  logic [OFFSET_W-1:0]   off;
  logic                  wrap;
  logic                  emit;

  always_comb begin
    priority if (stripe_bytes < MIN_STRIPE) begin
      bs_clamped = MIN_STRIPE;
    end else if (stripe_bytes > MAX_STRIPE) begin
      bs_clamped = MAX_STRIPE;
    end else begin
      bs_clamped = stripe_bytes;
    end
  end

  // two restoring steps per cycle, block number reduced by drive count in lockstep
  always_comb begin
    r_w = {1'b0, rem};
    d_w = dvd;
    m_w = rd;
    q_w = qd;
    t   = '0;
    qb  = 1'b0;
    u   = '0;
    q2b = 1'b0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t   = {r_w[BS_W-1:0], d_w[OFFSET_W-1]};
      qb  = (t >= {1'b0, bs});
      r_w = qb ? (t - {1'b0, bs}) : t;
      d_w = {d_w[OFFSET_W-2:0], 1'b0};
      u   = {m_w, qb};
      q2b = (u >= DRV_N);
      m_w = q2b ? RD_W'(u - DRV_N) : u[RD_W-1:0];
      q_w = {q_w[QD_W-2:0], q2b};
    end
  end

  assign prod = qd * bs;

  assign first     = (ctl.op == OP_FIRST);
  assign room      = first ? (bs - rem) : bs;
  assign fits      = ({1'b0, remaining} <= room);
  assign seg       = fits ? remaining : room[CNT_W-1:0];
  assign rem_after = remaining - seg;
  assign off       = base + (first ? {{(OFFSET_W-BS_W){1'b0}}, rem} : '0);
  assign wrap      = (rd == DRV_LAST);
  assign emit      = ctl.go && (ctl.op == OP_FIRST || ctl.op == OP_NEXT);

  assign stat.too_long = (byte_count > MAX_LEN);
  assign stat.div_more = (cnt != '0);
  assign stat.last     = (rem_after == '0);
  assign stat.out_free = !seg_valid || !seg_stall;

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      unique case (ctl.op)
        OP_LOAD: begin
          wr        <= action;
          bs        <= bs_clamped;
          dvd       <= byte_offset;
          rem       <= '0;
          rd        <= '0;
          qd        <= '0;
          cnt       <= STEP_W'(DIV_STEPS - 1);
          remaining <= byte_count;
        end
        OP_DIV: begin
          dvd <= d_w;
          rem <= r_w[BS_W-1:0];
          rd  <= m_w;
          qd  <= q_w;
          cnt <= cnt - 1'b1;
        end
        OP_MUL: begin
          base <= prod[OFFSET_W-1:0];
        end
        OP_FIRST, OP_NEXT: begin
          remaining <= rem_after;
          rd        <= wrap ? '0 : rd + 1'b1;
          if (wrap) begin
            base <= base + {{(OFFSET_W-BS_W){1'b0}}, bs};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (ctl.go && (emit || ctl.op == OP_REJECT)) begin
      seg_valid <= 1'b1;
    end else if (!seg_stall) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      is_write          <= wr;
      drive_index       <= rd[0];
      drive_byte_offset <= off;
      segment_bytes     <= seg;
      last_segment      <= (rem_after == '0);
      too_long          <= 1'b0;
    end else if (ctl.go && ctl.op == OP_REJECT) begin
      is_write          <= wr;
      drive_index       <= 1'b0;
      drive_byte_offset <= '0;
      segment_bytes     <= '0;
      last_segment      <= 1'b1;
      too_long          <= 1'b1;
    end
  end

  `SSPLIT_ASSERT_IMPLY(a_mid_seg_nonzero, seg_valid && !too_long && !last_segment,
                       segment_bytes != '0, "non-final segment with zero length")
  `SSPLIT_ASSERT_IMPLY(a_reject_shape, seg_valid && too_long,
                       last_segment && segment_bytes == '0 && drive_byte_offset == '0,
                       "rejected transaction not a single empty result")
  `SSPLIT_ASSERT_IMPLY(a_drive_range, emit, ({1'b0, rd} < DRV_N),
                       "drive remainder out of range")
  `SSPLIT_ASSERT_NEXT(a_emit_shows, emit, seg_valid, "emitted segment not presented")

endmodule

`default_nettype wire
